// ===== sv/dptt_pkg.sv =====
// Shared types and constants for the depth-preferred transposition table.
`default_nettype none
package dptt_pkg;

   // Slot count is a power of two; the slot index is the low key bits.
   localparam int IDX_W = 12;
   localparam int ENTRIES = 1 << IDX_W;
   localparam logic [IDX_W-1:0] SLOT_LAST = '1;

   localparam logic [1:0] MODE_STORE = 2'd0;
   localparam logic [1:0] MODE_PROBE = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] KIND_EMPTY = 2'd0;

   typedef struct packed {
      logic [1:0]         mode;
      logic [63:0]        key;
      logic [7:0]         search_depth;
      logic signed [15:0] store_score;
      logic [1:0]         bound_kind;
      logic [15:0]        move_code;
   } req_item_type;

   typedef struct packed {
      logic               key_matched;
      logic               full_hit;
      logic signed [15:0] hit_score;
      logic [15:0]        hit_move;
      logic [31:0]        hit_total;
      logic [31:0]        probe_total;
   } rsp_item_type;

   typedef struct packed {
      logic [63:0]        key;
      logic [7:0]         depth;
      logic signed [15:0] score;
      logic [1:0]         kind;
      logic [15:0]        move;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic probe;
      logic hit;
      logic clear;
   } eval_ctl_type;

   typedef struct packed {
      logic               key_matched;
      logic               full_hit;
      logic signed [15:0] hit_score;
      logic [15:0]        hit_move;
   } hit_info_type;

endpackage
`default_nettype wire

// ===== sv/depth_preferred_transposition_table_unit.sv =====
// Top level of the depth-preferred transposition table.
//
//   channel  dir  ports                           item
//   req      in   req_valid req_stall req_item    mode, key, depth, score, kind, move
//   rsp      out  rsp_valid rsp_stall rsp_item    match, hit, score, move, totals
//
// Store and probe first read the slot RAM, then evaluate and write back.
// One item in flight; the next item is taken while the result sits in rsp_item.
// After reset and after a clear item, a sweep zeroes all ENTRIES (4096) slots,
// one slot per cycle; req_stall is high throughout.
// A stalled rsp holds the result; the block then waits in the evaluate step.
`default_nettype none
module depth_preferred_transposition_table_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire dptt_pkg::req_item_type req_item,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      dptt_pkg::rsp_item_type rsp_item
);
   import dptt_pkg::*;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ} state_type;

   state_type    state_ff;
   logic [IDX_W-1:0] sweep_ff;
   req_item_type item_ff;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff;
   logic [31:0]  hit_total_ff;
   logic [31:0]  probe_total_ff;
   logic [31:0]  hit_total_in;
   logic [31:0]  probe_total_in;

   logic         accept;
   logic         out_free;
   logic         finish;
   logic         ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type    ram_wr_data;
   entry_type    ram_rd_data;
   eval_ctl_type ctl;
   hit_info_type info;
   entry_type    new_entry;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_READ) && out_free;

   dptt_eval u_eval (
      .item      (item_ff),
      .stored    (ram_rd_data),
      .ctl       (ctl),
      .info      (info),
      .new_entry (new_entry)
   );

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sweep_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = finish && ctl.wr_en;
         ram_wr_addr = item_ff.key[IDX_W-1:0];
         ram_wr_data = new_entry;
      end
      if (ctl.clear) begin
         hit_total_in   = '0;
         probe_total_in = '0;
      end else begin
         hit_total_in   = hit_total_ff + {31'd0, ctl.hit};
         probe_total_in = probe_total_ff + {31'd0, ctl.probe};
      end
   end

   dptt_ram #(
      .DATA_W ($bits(entry_type)),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_item.key[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         sweep_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         hit_total_ff   <= '0;
         probe_total_ff <= '0;
      end else begin
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               sweep_ff <= sweep_ff + {{(IDX_W-1){1'b0}}, 1'b1};
               if (sweep_ff == SLOT_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_item;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               if (out_free) begin
                  rsp_item_ff.key_matched  <= info.key_matched;
                  rsp_item_ff.full_hit     <= info.full_hit;
                  rsp_item_ff.hit_score    <= info.hit_score;
                  rsp_item_ff.hit_move     <= info.hit_move;
                  rsp_item_ff.hit_total    <= hit_total_in;
                  rsp_item_ff.probe_total  <= probe_total_in;
                  hit_total_ff             <= hit_total_in;
                  probe_total_ff           <= probe_total_in;
                  sweep_ff                 <= '0;
                  state_ff                 <= ctl.clear ? ST_CLEAR : ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
               sweep_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_probe_counts: assert property (@(posedge clock) disable iff (reset)
      (finish && item_ff.mode == MODE_PROBE) |=>
         (probe_total_ff == $past(probe_total_ff) + 32'd1))
      else $error("probe total did not advance on a probe");

   a_hit_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_item_ff.full_hit || rsp_item_ff.key_matched))
      else $error("full hit reported without key match");

   a_clear_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (finish && item_ff.mode == MODE_CLEAR) |=>
         (state_ff == ST_CLEAR && sweep_ff == '0 &&
          hit_total_ff == 32'd0 && probe_total_ff == 32'd0))
      else $error("clear item did not restart the sweep and counters");

   a_no_item_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (ram_wr_en && ram_wr_data == '0))
      else $error("sweep wrote a non-zero slot");

endmodule
`default_nettype wire

// ===== sv/dptt_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module dptt_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [1 << ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/dptt_eval.sv =====
// Slot evaluation: replacement decision on store, key and depth check on probe, counter clear on clear.
`default_nettype none
module dptt_eval (
   input  wire dptt_pkg::req_item_type item,
   input  wire dptt_pkg::entry_type    stored,
   output      dptt_pkg::eval_ctl_type ctl,
   output      dptt_pkg::hit_info_type info,
   output      dptt_pkg::entry_type    new_entry
);
   import dptt_pkg::*;

   logic occupied;
   logic matched;
   logic full;

   always_comb begin
      occupied = (stored.kind != KIND_EMPTY);
      matched  = occupied && (stored.key == item.key);
      full     = matched && (stored.depth >= item.search_depth);

      ctl = '0;
      info = '0;
      case (item.mode)
         MODE_STORE: begin
            ctl.wr_en = !occupied || (item.search_depth >= stored.depth);
         end
         MODE_PROBE: begin
            ctl.probe        = 1'b1;
            ctl.hit          = full;
            info.key_matched = matched;
            info.full_hit    = full;
            info.hit_score   = full ? stored.score : '0;
            info.hit_move    = matched ? stored.move : '0;
         end
         MODE_CLEAR: begin
            ctl.clear = 1'b1;
         end
         default: begin
         end
      endcase

      new_entry.key   = item.key;
      new_entry.depth = item.search_depth;
      new_entry.score = item.store_score;
      new_entry.kind  = item.bound_kind;
      new_entry.move  = item.move_code;
   end

endmodule
`default_nettype wire
